// ===== sv/bmss_pkg.sv =====
// Package for the brush mask sub-pixel shift block.
// Holds the shared widths, the register codes and the queue item type.
// No dependencies.
package bmss_pkg;

	// Largest mask side that the line buffer holds.
	localparam int MAX_SIDE = 256;
	localparam int CNT_W    = $clog2(MAX_SIDE);
	localparam int SIDE_W   = CNT_W + 1;

	// Configuration port.
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	// Pixel and fixed-point widths (fractions carry 8 fraction bits).
	localparam int PIX_W    = 8;
	localparam int FRAC_W   = 9;
	localparam int WEIGHT_W = 17;
	localparam int PROD_W   = PIX_W + WEIGHT_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int SHIFT    = 16;

	// Comparison width for clamping the side against the buffer depth.
	localparam int CMP_W = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

	// Depth of the queue between front and back; a power of two.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MASK_SIZE  = 2'd0,
		CFG_X_FRACTION = 2'd1,
		CFG_Y_FRACTION = 2'd2
	} cfg_index_t;

	// One classified pixel: the four neighbors with edges already zeroed.
	typedef struct packed {
		logic [PIX_W-1:0] ul;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] lf;
		logic [PIX_W-1:0] cur;
		logic             last;
	} bmss_item_t;

endpackage

// ===== sv/bmss_front.sv =====
// Front part of the brush mask sub-pixel shift block.
// Tracks the mask position, keeps the line buffer and gathers the neighbors of each item.
// Depends on bmss_pkg.
module bmss_front import bmss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [CNT_W-1:0]  side_m1,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  mask_pixel,
	output logic              push,
	output bmss_item_t        push_item,
	input  logic              q_full
);

	logic [PIX_W-1:0] line_mem [MAX_SIDE];
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [PIX_W-1:0] left_q;
	logic             valid_s1;
	logic [PIX_W-1:0] rd_s1;
	logic [PIX_W-1:0] cur_s1;
	logic [PIX_W-1:0] lf_s1;
	logic [PIX_W-1:0] ul_s1;
	logic             row0_s1;
	logic             last_s1;
	logic             accept;
	logic             col_end;
	logic             row_end;

	// The stage holds its item while the queue is full.
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign col_end  = (col_q == side_m1);
	assign row_end  = (row_q == side_m1);

	// Line buffer: the previous row is read before the current pixel overwrites it.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1          <= line_mem[col_q];
			line_mem[col_q] <= mask_pixel;
		end
	end

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Neighbor capture. The upper-left pixel is the line buffer word read for
	// the previous item, still held in rd_s1 at this edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= mask_pixel;
			cur_s1  <= mask_pixel;
			lf_s1   <= (col_q == '0) ? '0 : left_q;
			ul_s1   <= (col_q == '0 || row_q == '0) ? '0 : rd_s1;
			row0_s1 <= (row_q == '0);
			last_s1 <= col_end && row_end;
		end
	end

	// Item handed to the queue.
	always_comb begin
		push_item.ul   = ul_s1;
		push_item.up   = row0_s1 ? '0 : rd_s1;
		push_item.lf   = lf_s1;
		push_item.cur  = cur_s1;
		push_item.last = last_s1;
	end

endmodule

// ===== sv/bmss_queue.sv =====
// Short queue between the front and back parts of the sub-pixel shift block.
// Holds classified items so that each side can stall on its own.
// Depends on bmss_pkg.
module bmss_queue import bmss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bmss_item_t  push_item,
	input  logic        pop,
	output bmss_item_t  pop_item,
	output logic        full,
	output logic        empty
);

	bmss_item_t         entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count; pointers wrap since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front never writes a full queue and the back never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill count out of range");

endmodule

// ===== sv/bmss_back.sv =====
// Back part of the brush mask sub-pixel shift block.
// Forms the bilinear weights, multiplies the four neighbors and drives the result register.
// Depends on bmss_pkg.
module bmss_back import bmss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  x_fraction,
	input  logic [CFG_W-1:0]  y_fraction,
	input  logic              empty,
	input  bmss_item_t        pop_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  shifted_pixel,
	output logic              last_of_mask
);

	localparam logic [FRAC_W-1:0] ONE_FIX = FRAC_W'(256);

	logic [FRAC_W-1:0]   xf;
	logic [FRAC_W-1:0]   yf;
	logic [FRAC_W-1:0]   xf_inv;
	logic [FRAC_W-1:0]   yf_inv;
	logic [WEIGHT_W-1:0] w_ul_q;
	logic [WEIGHT_W-1:0] w_up_q;
	logic [WEIGHT_W-1:0] w_lf_q;
	logic [WEIGHT_W-1:0] w_cur_q;
	logic                valid_s2;
	logic [PROD_W-1:0]   p_ul_s2;
	logic [PROD_W-1:0]   p_up_s2;
	logic [PROD_W-1:0]   p_lf_s2;
	logic [PROD_W-1:0]   p_cur_s2;
	logic                last_s2;
	logic [SUM_W-1:0]    sum;
	logic                out_ready;
	logic                adv_s2;

	// Fractions above one saturate to one.
	assign xf     = (x_fraction > ONE_FIX) ? ONE_FIX : x_fraction;
	assign yf     = (y_fraction > ONE_FIX) ? ONE_FIX : y_fraction;
	assign xf_inv = ONE_FIX - xf;
	assign yf_inv = ONE_FIX - yf;

	// Weights are registered from the clamped fractions.
	always_ff @(posedge clk) begin
		w_ul_q  <= WEIGHT_W'(xf) * WEIGHT_W'(yf);
		w_up_q  <= WEIGHT_W'(xf_inv) * WEIGHT_W'(yf);
		w_lf_q  <= WEIGHT_W'(xf) * WEIGHT_W'(yf_inv);
		w_cur_q <= WEIGHT_W'(xf_inv) * WEIGHT_W'(yf_inv);
	end

	// Pipeline flow: the result register frees when empty or taken.
	assign out_ready = !out_valid || !out_stall;
	assign adv_s2    = valid_s2 && out_ready;
	assign pop       = !empty && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Multiply stage: one product per neighbor.
	always_ff @(posedge clk) begin
		if (pop) begin
			p_ul_s2  <= PROD_W'(pop_item.ul)  * PROD_W'(w_ul_q);
			p_up_s2  <= PROD_W'(pop_item.up)  * PROD_W'(w_up_q);
			p_lf_s2  <= PROD_W'(pop_item.lf)  * PROD_W'(w_lf_q);
			p_cur_s2 <= PROD_W'(pop_item.cur) * PROD_W'(w_cur_q);
			last_s2  <= pop_item.last;
		end
	end

	// Sum and truncate into the result register.
	assign sum = SUM_W'(p_ul_s2) + SUM_W'(p_up_s2) + SUM_W'(p_lf_s2) + SUM_W'(p_cur_s2);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			shifted_pixel <= sum[SHIFT +: PIX_W];
			last_of_mask  <= last_s2;
		end
	end

endmodule

// ===== sv/brush_mask_subpixel_shift.sv =====
// Top level of the brush mask sub-pixel shift block.
// Holds the configuration registers and joins the front, the queue and the back.
// Depends on bmss_pkg, bmss_front, bmss_queue and bmss_back.
//
// Usage:
// Source mask pixels enter in raster order on the input channel (in_valid,
// in_stall, mask_pixel); an item is taken at a clock edge with in_valid high
// and in_stall low. Every pixel yields one result on the output channel
// (out_valid, out_stall, shifted_pixel, last_of_mask), the bilinear blend of
// the pixel with its left, upper and upper-left neighbors, where neighbors
// outside the mask count as zero. last_of_mask marks the final pixel.
// Throughput is one pixel per cycle unless the receiver stalls: one line buffer
// read and write and four weight products per item. A result passes the neighbor
// stage, the queue entry, the multiply stage and the result register. While the
// receiver stalls, the result register, the multiply stage, the two-entry queue
// and the front stage fill up before in_stall rises. Reset sets mask_size to 1
// and both fractions to 0, and restarts at row 0, column 0. Writing mask_size
// restarts the mask; fraction writes take effect for the next pixel. The user
// writes configuration only while the block is idle; no logic enforces this.
module brush_mask_subpixel_shift import bmss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     mask_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     shifted_pixel,
	output logic                 last_of_mask
);

	logic [CFG_W-1:0] mask_size_q;
	logic [CFG_W-1:0] x_fraction_q;
	logic [CFG_W-1:0] y_fraction_q;
	logic             restart;
	logic [CMP_W-1:0] size_wide;
	logic [CNT_W-1:0] side_m1;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	bmss_item_t       push_item;
	bmss_item_t       pop_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_size_q  <= CFG_W'(1);
			x_fraction_q <= '0;
			y_fraction_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MASK_SIZE:  mask_size_q  <= cfg_data;
				CFG_X_FRACTION: x_fraction_q <= cfg_data;
				CFG_Y_FRACTION: y_fraction_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == CFG_MASK_SIZE);

	// Side clamped to 1..MAX_SIDE, kept as side minus one.
	assign size_wide = CMP_W'(mask_size_q);

	always_comb begin
		if (size_wide == '0) begin
			side_m1 = '0;
		end else if (size_wide > CMP_W'(MAX_SIDE)) begin
			side_m1 = CNT_W'(MAX_SIDE - 1);
		end else begin
			side_m1 = CNT_W'(size_wide - 1'b1);
		end
	end

	bmss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.side_m1    (side_m1),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mask_pixel (mask_pixel),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	bmss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	bmss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.x_fraction    (x_fraction_q),
		.y_fraction    (y_fraction_q),
		.empty         (q_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.shifted_pixel (shifted_pixel),
		.last_of_mask  (last_of_mask)
	);

endmodule

// ===== sim/tb_brush_mask_subpixel_shift.sv =====
// Self-checking testbench for brush_mask_subpixel_shift: streams mask pixels and
// register writes, predicts every shifted pixel and compares it on the output channel.
// Depends on bmss_pkg and the brush_mask_subpixel_shift RTL.
module tb_brush_mask_subpixel_shift;
	import bmss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Register index with no register behind it; writes to it change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int unsigned ONE_FIX       = 256;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned RANDOM_ITEMS  = 1050;

	// One entry of the stimulus stream: a pixel item or a register write.
	typedef struct {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
		int unsigned          gap;
	} stim_entry_t;

	// One predicted output pixel.
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} shifted_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = CFG_MASK_SIZE;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     mask_pixel = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [PIX_W-1:0]     shifted_pixel;
	logic                 last_of_mask;

	stim_entry_t     source_stream[$];
	shifted_result_t expected_shifts[$];

	// Predictor state: registers, line buffer, neighbors and position.
	logic [CFG_W-1:0] reg_mask_size  = 9'd1;
	logic [CFG_W-1:0] reg_x_fraction = '0;
	logic [CFG_W-1:0] reg_y_fraction = '0;
	logic [PIX_W-1:0] line_row [MAX_SIDE];
	logic [PIX_W-1:0] left_q         = '0;
	logic [PIX_W-1:0] upper_left_q   = '0;
	int unsigned      column_pos     = 0;
	int unsigned      row_pos        = 0;

	int unsigned pixels_queued  = 0;
	int unsigned writes_queued  = 0;
	int unsigned pixels_taken   = 0;
	int unsigned results_seen   = 0;
	int unsigned masks_finished = 0;
	int unsigned failures       = 0;
	int unsigned sender_gap_max = 0;

	brush_mask_subpixel_shift DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mask_pixel   (mask_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.shifted_pixel(shifted_pixel),
		.last_of_mask (last_of_mask)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A size write restarts the mask and clears the neighbors; fractions only latch.
	function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		if (idx == CFG_MASK_SIZE) begin
			reg_mask_size = val;
			column_pos    = 0;
			row_pos       = 0;
			left_q        = '0;
			upper_left_q  = '0;
		end else if (idx == CFG_X_FRACTION) begin
			reg_x_fraction = val;
		end else if (idx == CFG_Y_FRACTION) begin
			reg_y_fraction = val;
		end
	endfunction

	// Blends one source pixel with its left, upper and upper-left neighbors and
	// advances the line buffer and the position in the mask.
	function automatic shifted_result_t blend_next_pixel(input logic [PIX_W-1:0] cur);
		int unsigned      side, xf, yf, col, row, up, ul, lf;
		logic [31:0]      acc;
		logic [PIX_W-1:0] stored;
		shifted_result_t  res;
		side = reg_mask_size;
		if (side < 1) side = 1;
		if (side > MAX_SIDE) side = MAX_SIDE;
		xf = (reg_x_fraction > ONE_FIX) ? ONE_FIX : reg_x_fraction;
		yf = (reg_y_fraction > ONE_FIX) ? ONE_FIX : reg_y_fraction;
		col = column_pos;
		row = row_pos;
		if (col >= side) col = side - 1;
		if (row >= side) row = side - 1;

		// Neighbors outside the mask count as zero.
		stored = line_row[col];
		up = (row == 0) ? 0 : stored;
		ul = (row == 0 || col == 0) ? 0 : upper_left_q;
		lf = (col == 0) ? 0 : left_q;
		acc = ul * (xf * yf) + up * ((ONE_FIX - xf) * yf)
			+ lf * (xf * (ONE_FIX - yf)) + cur * ((ONE_FIX - xf) * (ONE_FIX - yf));

		upper_left_q = (row == 0) ? '0 : stored;
		line_row[col] = cur;
		left_q = cur;

		res.last = 1'b0;
		if (col + 1 >= side) begin
			column_pos   = 0;
			left_q       = '0;
			upper_left_q = '0;
			if (row + 1 >= side) begin
				row_pos  = 0;
				res.last = 1'b1;
			end else begin
				row_pos = row + 1;
			end
		end else begin
			column_pos = col + 1;
			row_pos    = row;
		end
		res.pixel = acc[23:16];
		return res;
	endfunction

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		stim_entry_t e;
		e.is_write = 1'b1;
		e.index    = idx;
		e.data     = val;
		e.gap      = 0;
		source_stream.push_back(e);
		writes_queued++;
	endtask

	task automatic add_pixel(input logic [PIX_W-1:0] val);
		stim_entry_t e;
		e.is_write = 1'b0;
		e.index    = CFG_MASK_SIZE;
		e.data     = {1'b0, val};
		e.gap      = $urandom_range(0, sender_gap_max);
		source_stream.push_back(e);
		pixels_queued++;
	endtask

	// Opacity values lean toward the extremes now and then.
	function automatic logic [PIX_W-1:0] random_opacity();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// Fractions cover zero, exactly one, values above one and the open range.
	function automatic logic [CFG_W-1:0] random_fraction();
		case ($urandom_range(0, 5))
			0: begin
				return 9'd0;
			end
			1: begin
				return 9'd256;
			end
			2: begin
				return 9'($urandom_range(257, 511));
			end
			default: begin
				return 9'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic add_random_pixels(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			add_pixel(random_opacity());
		end
	endtask

	// Driver: presents pixel items and performs register writes once the block is idle.
	int unsigned gap_left    = 0;
	int unsigned settle_left = SETTLE_CYCLES;
	always @(posedge clk) begin : driver
		stim_entry_t entry;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we   <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_shifts.push_back(blend_next_pixel(mask_pixel));
				pixels_taken++;
			end
			if (in_valid && in_stall) begin
				cfg_we <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
				cfg_we   <= 1'b0;
			end else if (source_stream.size() == 0) begin
				in_valid <= 1'b0;
				cfg_we   <= 1'b0;
			end else if (source_stream[0].is_write) begin
				in_valid <= 1'b0;
				if (expected_shifts.size() != 0) begin
					settle_left <= SETTLE_CYCLES;
					cfg_we      <= 1'b0;
				end else if (settle_left != 0) begin
					settle_left <= settle_left - 1;
					cfg_we      <= 1'b0;
				end else begin
					entry = source_stream.pop_front();
					apply_register_write(entry.index, entry.data);
					cfg_index <= entry.index;
					cfg_data  <= entry.data;
					cfg_we    <= 1'b1;
				end
			end else begin
				entry = source_stream.pop_front();
				mask_pixel <= entry.data[PIX_W-1:0];
				in_valid   <= 1'b1;
				gap_left   <= entry.gap;
				cfg_we     <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted result and stalls at random, in bursts and quiet runs.
	int unsigned stall_left    = 0;
	int unsigned out_idle_max  = 9;
	int unsigned until_switch  = 40;
	always @(posedge clk) begin : monitor
		shifted_result_t want;
		int unsigned     n;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_valid && !out_stall) begin
			results_seen++;
			if (last_of_mask) masks_finished++;
			if (expected_shifts.size() == 0) begin
				$error("unexpected item: shifted_pixel %0d, last_of_mask %0d",
					shifted_pixel, last_of_mask);
				failures++;
			end else begin
				want = expected_shifts.pop_front();
				if (shifted_pixel !== want.pixel) begin
					$error("shifted_pixel: expected %0d, actual %0d", want.pixel, shifted_pixel);
					failures++;
				end
				if (last_of_mask !== want.last) begin
					$error("last_of_mask: expected %0d, actual %0d", want.last, last_of_mask);
					failures++;
				end
			end
			if (until_switch == 0) begin
				out_idle_max = (out_idle_max == 0) ? 9 : 0;
				until_switch = $urandom_range(16, 96);
			end else begin
				until_switch--;
			end
			n = $urandom_range(0, out_idle_max);
			stall_left <= n;
			out_stall  <= (n != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end
	end

	// Stimulus script, reset and end of run.
	initial begin : script
		int unsigned pick, side, count, part, large_runs;
		logic [CFG_W-1:0] size_val;
		for (int i = 0; i < MAX_SIDE; i++) line_row[i] = '0;

		// Directed: a 3x3 checkerboard with a full last row and half shifts covers edges and extremes.
		add_write(CFG_MASK_SIZE, 9'd3);
		add_write(CFG_X_FRACTION, 9'd128);
		add_write(CFG_Y_FRACTION, 9'd128);
		add_pixel(8'hFF); add_pixel(8'h00); add_pixel(8'hFF);
		add_pixel(8'h00); add_pixel(8'hFF); add_pixel(8'h00);
		add_pixel(8'hFF); add_pixel(8'hFF); add_pixel(8'hFF);
		// Fractions above one saturate to a full shift.
		add_write(CFG_MASK_SIZE, 9'd2);
		add_write(CFG_X_FRACTION, 9'd300);
		add_write(CFG_Y_FRACTION, 9'd511);
		add_pixel(8'hFF); add_pixel(8'hFF); add_pixel(8'h80); add_pixel(8'h01);
		// A zero size counts as one pixel per mask.
		add_write(CFG_MASK_SIZE, 9'd0);
		add_write(CFG_X_FRACTION, 9'd0);
		add_write(CFG_Y_FRACTION, 9'd256);
		add_pixel(8'hFF); add_pixel(8'h00);
		add_write(CFG_MASK_SIZE, 9'd1);
		add_write(CFG_X_FRACTION, 9'd256);
		add_write(CFG_Y_FRACTION, 9'd0);
		add_pixel(8'hFF); add_pixel(8'h7F);
		// A size write mid-mask restarts it; a fraction write mid-mask does not.
		add_write(CFG_MASK_SIZE, 9'd3);
		add_write(CFG_X_FRACTION, 9'd64);
		add_write(CFG_Y_FRACTION, 9'd192);
		add_pixel(8'hFF); add_pixel(8'hC0); add_pixel(8'h40); add_pixel(8'hFF);
		add_write(CFG_MASK_SIZE, 9'd3);
		add_pixel(8'h33); add_pixel(8'hFF); add_pixel(8'hAA);
		add_write(CFG_X_FRACTION, 9'd200);
		add_write(CFG_SPARE, 9'h1FF);
		add_pixel(8'hFF); add_pixel(8'h00); add_pixel(8'h55);

		// Random phases: mostly small masks, a few with the largest side.
		large_runs = 0;
		side = 3;
		while (pixels_queued < RANDOM_ITEMS) begin
			sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			pick = $urandom_range(0, 19);
			if (pick == 0 && large_runs < 2) begin
				size_val = (large_runs == 0) ? 9'd256 : 9'($urandom_range(257, 511));
				large_runs++;
				side = MAX_SIDE;
				add_write(CFG_MASK_SIZE, size_val);
				count = side + $urandom_range(1, 40);
			end else if (pick < 4) begin
				// Carry on in the current mask without a restart.
				count = $urandom_range(1, 30);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					size_val = 9'($urandom_range(0, 1));
				end else if (pick < 7) begin
					size_val = 9'($urandom_range(2, 6));
				end else begin
					size_val = 9'($urandom_range(7, 20));
				end
				side = (size_val == 0) ? 1 : size_val;
				add_write(CFG_MASK_SIZE, size_val);
				if (side <= 6) begin
					count = side * side * $urandom_range(1, 3);
				end else if (side <= 12) begin
					count = side * side;
				end else begin
					count = side * $urandom_range(2, 6) + $urandom_range(0, side - 1);
				end
				if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
			end
			if ($urandom_range(0, 3) != 0) add_write(CFG_X_FRACTION, random_fraction());
			if ($urandom_range(0, 3) != 0) add_write(CFG_Y_FRACTION, random_fraction());
			if ($urandom_range(0, 11) == 0) add_write(CFG_SPARE, 9'($urandom_range(0, 511)));
			if ($urandom_range(0, 5) == 0 && count > 1) begin
				part = $urandom_range(1, count - 1);
				add_random_pixels(part);
				add_write(CFG_X_FRACTION, random_fraction());
				add_random_pixels(count - part);
			end else begin
				add_random_pixels(count);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to be taken and every result to be checked.
		@(negedge clk);
		while (source_stream.size() != 0 || pixels_taken != pixels_queued
				|| expected_shifts.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_shifts.size() != 0) begin
			$error("%0d expected results never arrived", expected_shifts.size());
			failures++;
		end

		$display("Run covered %0d pixels and %0d register writes, %0d masks completed.",
			pixels_taken, writes_queued, masks_finished);
		$display("Results checked: %0d, failures: %0d.", results_seen, failures);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
